### rtl/sta_pkg.sv
`timescale 1ns / 1ps
// Shared types and codes for the slot table with hole FIFO.
// No dependencies.
package sta_pkg;

    localparam logic [3:0] ACT_ADD    = 4'd0;
    localparam logic [3:0] ACT_UPDATE = 4'd1;
    localparam logic [3:0] ACT_REMOVE = 4'd2;
    localparam logic [3:0] ACT_READ   = 4'd3;
    localparam logic [3:0] ACT_QUERY  = 4'd4;
    localparam logic [3:0] ACT_FIRST  = 4'd5;
    localparam logic [3:0] ACT_NEXT   = 4'd6;
    localparam logic [3:0] ACT_LAST   = 4'd7;
    localparam logic [3:0] ACT_PREV   = 4'd8;
    localparam logic [3:0] ACT_MAXID  = 4'd9;

    localparam logic [2:0] STS_OK      = 3'd0;
    localparam logic [2:0] STS_NONE    = 3'd1;
    localparam logic [2:0] STS_DUP     = 3'd2;
    localparam logic [2:0] STS_FULL    = 3'd3;
    localparam logic [2:0] STS_INVALID = 3'd4;

    typedef enum logic [6:0] {
        ST_IDLE  = 7'b0000001,
        ST_EXEC  = 7'b0000010,
        ST_SCAN  = 7'b0000100,
        ST_INS   = 7'b0001000,
        ST_FETCH = 7'b0010000,
        ST_LOAD  = 7'b0100000,
        ST_RESP  = 7'b1000000
    } state_t;

    typedef struct packed {
        logic start;
        logic fwd;
        logic key_mode;
    } scan_ctl_t;

    typedef struct packed {
        logic done;
        logic hit;
    } scan_res_t;

    typedef struct packed {
        logic data_we;
        logic entry_we;
        logic keyed;
        logic clr_en;
    } store_wr_t;

endpackage

### rtl/sta_store.sv
`timescale 1ns / 1ps
// Slot storage: data and key memories plus valid and keyed marks.
// Depends on sta_pkg.
module sta_store
    import sta_pkg::*;
#(
    parameter int CAPACITY   = 64,
    parameter int DATA_WIDTH = 32,
    parameter int KEY_WIDTH  = 32,
    localparam int ID_W      = $clog2(CAPACITY)
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  store_wr_t             wr,
    input  logic [ID_W-1:0]       wr_addr,
    input  logic [DATA_WIDTH-1:0] wr_data,
    input  logic [KEY_WIDTH-1:0]  wr_key,
    input  logic [ID_W-1:0]       data_rd_addr,
    input  logic [ID_W-1:0]       key_rd_addr,
    output logic [DATA_WIDTH-1:0] data_q,
    output logic [KEY_WIDTH-1:0]  key_q,
    output logic [CAPACITY-1:0]   valid_vec,
    output logic [CAPACITY-1:0]   keyed_vec
);

    logic [DATA_WIDTH-1:0] data_mem [CAPACITY];
    logic [KEY_WIDTH-1:0]  key_mem  [CAPACITY];
    logic [CAPACITY-1:0]   valid_reg;
    logic [CAPACITY-1:0]   keyed_reg;
    logic [CAPACITY-1:0]   valid_next;
    logic [CAPACITY-1:0]   keyed_next;

    always_ff @(posedge clk)
    begin
        if (wr.data_we || wr.entry_we)
        begin
            data_mem[wr_addr] <= wr_data;
        end
        if (wr.entry_we)
        begin
            key_mem[wr_addr] <= wr_key;
        end
        data_q <= data_mem[data_rd_addr];
        key_q  <= key_mem[key_rd_addr];
    end

    always_comb
    begin
        valid_next = valid_reg;
        keyed_next = keyed_reg;
        if (wr.entry_we)
        begin
            valid_next[wr_addr] = 1'b1;
            keyed_next[wr_addr] = wr.keyed;
        end
        else if (wr.clr_en)
        begin
            valid_next[wr_addr] = 1'b0;
            keyed_next[wr_addr] = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            keyed_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
            keyed_reg <= keyed_next;
        end
    end

    assign valid_vec = valid_reg;
    assign keyed_vec = keyed_reg;

endmodule

### rtl/sta_hole_fifo.sv
`timescale 1ns / 1ps
// FIFO of freed slot ids, held in a memory with a registered head read.
// Depends on sta_pkg.
module sta_hole_fifo
    import sta_pkg::*;
#(
    parameter int CAPACITY = 64,
    localparam int ID_W    = $clog2(CAPACITY),
    localparam int CNT_W   = $clog2(CAPACITY + 1)
)
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  logic [ID_W-1:0] push_id,
    input  logic            pop,
    output logic [ID_W-1:0] head_id,
    output logic            not_empty
);

    logic [ID_W-1:0]  fifo_mem [CAPACITY];
    logic [ID_W-1:0]  head_reg, head_next;
    logic [ID_W-1:0]  tail_reg, tail_next;
    logic [CNT_W-1:0] count_reg, count_next;

    localparam logic [ID_W-1:0] LAST_IDX = ID_W'(CAPACITY - 1);

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            fifo_mem[tail_reg] <= push_id;
        end
        // head is read back through a register; ops never come back to back
        head_id <= fifo_mem[head_reg];
    end

    always_comb
    begin
        head_next  = head_reg;
        tail_next  = tail_reg;
        count_next = count_reg;
        if (push)
        begin
            tail_next  = (tail_reg == LAST_IDX) ? '0 : tail_reg + 1'b1;
            count_next = count_reg + 1'b1;
        end
        else if (pop)
        begin
            head_next  = (head_reg == LAST_IDX) ? '0 : head_reg + 1'b1;
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
        end
    end

    assign not_empty = (count_reg != '0);

endmodule

### rtl/sta_scan.sv
`timescale 1ns / 1ps
// Shared slot scanner: walks slots one per cycle forward or backward and
// stops on the first valid (and, in key mode, matching keyed) slot. Uses sta_pkg.
module sta_scan
    import sta_pkg::*;
#(
    parameter int CAPACITY  = 64,
    parameter int KEY_WIDTH = 32,
    localparam int ID_W     = $clog2(CAPACITY),
    localparam int CNT_W    = $clog2(CAPACITY + 1)
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  scan_ctl_t            ctl,
    input  logic [CNT_W-1:0]     start_pos,
    input  logic [CNT_W-1:0]     limit,
    input  logic [KEY_WIDTH-1:0] key,
    input  logic [KEY_WIDTH-1:0] key_rd,
    input  logic [CAPACITY-1:0]  valid_vec,
    input  logic [CAPACITY-1:0]  keyed_vec,
    output logic [ID_W-1:0]      rd_addr,
    output scan_res_t            res,
    output logic [ID_W-1:0]      hit_idx
);

    logic [CNT_W-1:0] pos_reg, pos_next;
    logic [CNT_W-1:0] limit_reg, limit_next;
    logic [ID_W-1:0]  cmp_idx_reg, cmp_idx_next;
    logic             active_reg, active_next;
    logic             cmp_vld_reg, cmp_vld_next;
    logic             fwd_reg, fwd_next;
    logic             keym_reg, keym_next;
    logic [CNT_W-1:0] pos_dec;
    logic             more;
    logic             match;

    assign pos_dec = pos_reg - 1'b1;
    assign more    = fwd_reg ? (pos_reg < limit_reg) : (pos_reg != '0);
    assign rd_addr = fwd_reg ? pos_reg[ID_W-1:0] : pos_dec[ID_W-1:0];

    // key memory data lines up with cmp_idx_reg (registered read)
    assign match = cmp_vld_reg && valid_vec[cmp_idx_reg]
                   && (!keym_reg || (keyed_vec[cmp_idx_reg] && key_rd == key));

    assign res.hit  = match;
    assign res.done = active_reg && (match || (!cmp_vld_reg && !more));
    assign hit_idx  = cmp_idx_reg;

    always_comb
    begin
        pos_next     = pos_reg;
        limit_next   = limit_reg;
        cmp_idx_next = cmp_idx_reg;
        active_next  = active_reg;
        cmp_vld_next = 1'b0;
        fwd_next     = fwd_reg;
        keym_next    = keym_reg;
        if (ctl.start)
        begin
            active_next = 1'b1;
            pos_next    = start_pos;
            limit_next  = limit;
            fwd_next    = ctl.fwd;
            keym_next   = ctl.key_mode;
        end
        else if (res.done)
        begin
            active_next = 1'b0;
        end
        else if (active_reg && more)
        begin
            cmp_vld_next = 1'b1;
            cmp_idx_next = rd_addr;
            pos_next     = fwd_reg ? pos_reg + 1'b1 : pos_dec;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg  <= 1'b0;
            cmp_vld_reg <= 1'b0;
            pos_reg     <= '0;
            limit_reg   <= '0;
            cmp_idx_reg <= '0;
            fwd_reg     <= 1'b0;
            keym_reg    <= 1'b0;
        end
        else
        begin
            active_reg  <= active_next;
            cmp_vld_reg <= cmp_vld_next;
            pos_reg     <= pos_next;
            limit_reg   <= limit_next;
            cmp_idx_reg <= cmp_idx_next;
            fwd_reg     <= fwd_next;
            keym_reg    <= keym_next;
        end
    end

endmodule

### rtl/slot_table_with_hole_fifo_unit.sv
`timescale 1ns / 1ps
// Slot table with a FIFO of freed slots: top level sequencer.
// Depends on sta_pkg, sta_store, sta_hole_fifo and sta_scan.
//
// One request at a time: in_ready is high only while the unit is idle and
// each request yields one result on the out channel. After the input
// transfer the request passes through ST_EXEC; remove and unknown actions
// then go to ST_RESP, add and update without a key through ST_INS, read
// through ST_FETCH and ST_LOAD. Key lookups (keyed add/update, query),
// walks and max id run the shared slot scanner in ST_SCAN, one slot per
// cycle over at most high-water slots (CAPACITY at most). No clearing pass
// after reset.
module slot_table_with_hole_fifo_unit
    import sta_pkg::*;
#(
    parameter int CAPACITY   = 64,
    parameter int DATA_WIDTH = 32,
    parameter int KEY_WIDTH  = 32,
    localparam int ID_W      = $clog2(CAPACITY),
    localparam int CNT_W     = $clog2(CAPACITY + 1)
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_wr_en,
    input  logic                  cfg_wr_data,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [3:0]            action,
    input  logic [ID_W-1:0]       slot_id,
    input  logic [DATA_WIDTH-1:0] payload,
    input  logic [KEY_WIDTH-1:0]  lookup_key,
    input  logic                  key_present,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [2:0]            status,
    output logic [ID_W-1:0]       result_id,
    output logic [DATA_WIDTH-1:0] result_data,
    output logic [CNT_W-1:0]      live_count
);

    localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

    state_t                state_reg, state_next;
    logic                  key_en_reg;
    logic [3:0]            act_reg;
    logic [ID_W-1:0]       sid_reg;
    logic [DATA_WIDTH-1:0] pay_reg;
    logic [KEY_WIDTH-1:0]  key_reg;
    logic                  kp_reg;
    logic [2:0]            status_reg, status_next;
    logic [ID_W-1:0]       rid_reg, rid_next;
    logic [DATA_WIDTH-1:0] rdata_reg, rdata_next;
    logic [ID_W-1:0]       fetch_reg, fetch_next;
    logic [CNT_W-1:0]      hw_reg, hw_next;
    logic [CNT_W-1:0]      cnt_reg, cnt_next;
    logic [CNT_W-1:0]      cursor_reg, cursor_next;

    store_wr_t             wr;
    logic [ID_W-1:0]       wr_addr;
    logic [DATA_WIDTH-1:0] data_q;
    logic [KEY_WIDTH-1:0]  key_q;
    logic [CAPACITY-1:0]   valid_vec;
    logic [CAPACITY-1:0]   keyed_vec;
    logic                  hole_push;
    logic                  hole_pop;
    logic [ID_W-1:0]       hole_id;
    logic                  hole_avail;
    scan_ctl_t             scan_ctl;
    scan_res_t             scan_res;
    logic [CNT_W-1:0]      scan_start;
    logic [ID_W-1:0]       scan_addr;
    logic [ID_W-1:0]       scan_hit_idx;
    logic                  sid_ok;
    logic [CNT_W:0]        cur_inc;
    logic [CNT_W-1:0]      next_start;
    logic                  is_walk;
    logic                  is_fwd_walk;

    assign sid_ok = (CNT_W'(sid_reg) < hw_reg) && valid_vec[sid_reg];
    assign cur_inc = {1'b0, cursor_reg} + 1'b1;
    assign next_start = (cur_inc > {1'b0, hw_reg}) ? hw_reg : cur_inc[CNT_W-1:0];
    assign is_walk = (act_reg == ACT_FIRST) || (act_reg == ACT_NEXT)
                     || (act_reg == ACT_LAST) || (act_reg == ACT_PREV);
    assign is_fwd_walk = (act_reg == ACT_FIRST) || (act_reg == ACT_NEXT);

    always_comb
    begin
        state_next  = state_reg;
        status_next = status_reg;
        rid_next    = rid_reg;
        rdata_next  = rdata_reg;
        fetch_next  = fetch_reg;
        hw_next     = hw_reg;
        cnt_next    = cnt_reg;
        cursor_next = cursor_reg;
        wr          = '0;
        wr_addr     = sid_reg;
        hole_push   = 1'b0;
        hole_pop    = 1'b0;
        scan_ctl    = '0;
        scan_start  = '0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                status_next = STS_OK;
                rid_next    = '0;
                rdata_next  = '0;
                state_next  = ST_RESP;
                unique case (act_reg)
                    ACT_ADD, ACT_UPDATE:
                    begin
                        if (kp_reg && !key_en_reg)
                        begin
                            status_next = STS_INVALID;
                        end
                        else if (kp_reg)
                        begin
                            scan_ctl   = '{start: 1'b1, fwd: 1'b1, key_mode: 1'b1};
                            state_next = ST_SCAN;
                        end
                        else
                        begin
                            state_next = ST_INS;
                        end
                    end
                    ACT_REMOVE:
                    begin
                        if (sid_ok)
                        begin
                            wr.clr_en = 1'b1;
                            hole_push = 1'b1;
                            cnt_next  = cnt_reg - 1'b1;
                            rid_next  = sid_reg;
                        end
                        else
                        begin
                            status_next = STS_INVALID;
                        end
                    end
                    ACT_READ:
                    begin
                        if (sid_ok)
                        begin
                            rid_next   = sid_reg;
                            fetch_next = sid_reg;
                            state_next = ST_FETCH;
                        end
                        else
                        begin
                            status_next = STS_NONE;
                        end
                    end
                    ACT_QUERY:
                    begin
                        if (!key_en_reg)
                        begin
                            status_next = STS_INVALID;
                        end
                        else
                        begin
                            scan_ctl   = '{start: 1'b1, fwd: 1'b1, key_mode: 1'b1};
                            state_next = ST_SCAN;
                        end
                    end
                    ACT_FIRST:
                    begin
                        scan_ctl   = '{start: 1'b1, fwd: 1'b1, key_mode: 1'b0};
                        state_next = ST_SCAN;
                    end
                    ACT_NEXT:
                    begin
                        scan_ctl   = '{start: 1'b1, fwd: 1'b1, key_mode: 1'b0};
                        scan_start = next_start;
                        state_next = ST_SCAN;
                    end
                    ACT_LAST, ACT_MAXID:
                    begin
                        scan_ctl   = '{start: 1'b1, fwd: 1'b0, key_mode: 1'b0};
                        scan_start = hw_reg;
                        state_next = ST_SCAN;
                    end
                    ACT_PREV:
                    begin
                        scan_ctl   = '{start: 1'b1, fwd: 1'b0, key_mode: 1'b0};
                        scan_start = (cursor_reg > hw_reg) ? hw_reg : cursor_reg;
                        state_next = ST_SCAN;
                    end
                    default:
                    begin
                        status_next = STS_INVALID;
                    end
                endcase
            end
            ST_SCAN:
            begin
                if (scan_res.done)
                begin
                    if (act_reg == ACT_ADD || act_reg == ACT_UPDATE)
                    begin
                        if (!scan_res.hit)
                        begin
                            state_next = ST_INS;
                        end
                        else
                        begin
                            rid_next   = scan_hit_idx;
                            state_next = ST_RESP;
                            if (act_reg == ACT_ADD)
                            begin
                                status_next = STS_DUP;
                            end
                            else
                            begin
                                wr.data_we = 1'b1;
                                wr_addr    = scan_hit_idx;
                            end
                        end
                    end
                    else
                    begin
                        if (scan_res.hit)
                        begin
                            rid_next   = scan_hit_idx;
                            fetch_next = scan_hit_idx;
                            state_next = ST_FETCH;
                        end
                        else
                        begin
                            status_next = STS_NONE;
                            state_next  = ST_RESP;
                        end
                        if (is_walk)
                        begin
                            if (scan_res.hit)
                            begin
                                cursor_next = CNT_W'(scan_hit_idx);
                            end
                            else
                            begin
                                cursor_next = is_fwd_walk ? hw_reg : '0;
                            end
                        end
                    end
                end
            end
            ST_INS:
            begin
                state_next = ST_RESP;
                if (hole_avail)
                begin
                    hole_pop    = 1'b1;
                    wr.entry_we = 1'b1;
                    wr.keyed    = kp_reg;
                    wr_addr     = hole_id;
                    rid_next    = hole_id;
                    cnt_next    = cnt_reg + 1'b1;
                end
                else if (hw_reg < CAP_CNT)
                begin
                    wr.entry_we = 1'b1;
                    wr.keyed    = kp_reg;
                    wr_addr     = hw_reg[ID_W-1:0];
                    rid_next    = hw_reg[ID_W-1:0];
                    hw_next     = hw_reg + 1'b1;
                    cnt_next    = cnt_reg + 1'b1;
                end
                else
                begin
                    status_next = STS_FULL;
                end
            end
            ST_FETCH:
            begin
                state_next = ST_LOAD;
            end
            ST_LOAD:
            begin
                rdata_next = data_q;
                state_next = ST_RESP;
            end
            ST_RESP:
            begin
                if (out_ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            key_en_reg <= 1'b0;
            status_reg <= STS_OK;
            rid_reg    <= '0;
            hw_reg     <= '0;
            cnt_reg    <= '0;
            cursor_reg <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            status_reg <= status_next;
            rid_reg    <= rid_next;
            hw_reg     <= hw_next;
            cnt_reg    <= cnt_next;
            cursor_reg <= cursor_next;
            if (cfg_wr_en)
            begin
                key_en_reg <= cfg_wr_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        rdata_reg <= rdata_next;
        fetch_reg <= fetch_next;
        if (in_valid && in_ready)
        begin
            act_reg <= action;
            sid_reg <= slot_id;
            pay_reg <= payload;
            key_reg <= lookup_key;
            kp_reg  <= key_present;
        end
    end

    sta_store #(
        .CAPACITY   (CAPACITY),
        .DATA_WIDTH (DATA_WIDTH),
        .KEY_WIDTH  (KEY_WIDTH)
    ) u_store (
        .clk          (clk),
        .rst_n        (rst_n),
        .wr           (wr),
        .wr_addr      (wr_addr),
        .wr_data      (pay_reg),
        .wr_key       (key_reg),
        .data_rd_addr (fetch_reg),
        .key_rd_addr  (scan_addr),
        .data_q       (data_q),
        .key_q        (key_q),
        .valid_vec    (valid_vec),
        .keyed_vec    (keyed_vec)
    );

    sta_hole_fifo #(
        .CAPACITY (CAPACITY)
    ) u_holes (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (hole_push),
        .push_id   (sid_reg),
        .pop       (hole_pop),
        .head_id   (hole_id),
        .not_empty (hole_avail)
    );

    sta_scan #(
        .CAPACITY  (CAPACITY),
        .KEY_WIDTH (KEY_WIDTH)
    ) u_scan (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (scan_ctl),
        .start_pos (scan_start),
        .limit     (hw_reg),
        .key       (key_reg),
        .key_rd    (key_q),
        .valid_vec (valid_vec),
        .keyed_vec (keyed_vec),
        .rd_addr   (scan_addr),
        .res       (scan_res),
        .hit_idx   (scan_hit_idx)
    );

    assign in_ready    = (state_reg == ST_IDLE);
    assign out_valid   = (state_reg == ST_RESP);
    assign status      = status_reg;
    assign result_id   = rid_reg;
    assign result_data = rdata_reg;
    assign live_count  = cnt_reg;

endmodule

### rtl/sta_checker.sv
`timescale 1ns / 1ps
// Port-level checks for the slot table, bound to the top level.
// Depends on slot_table_with_hole_fifo_unit and sta_pkg.
module sta_checker
    import sta_pkg::*;
#(
    parameter int CAPACITY   = 64,
    parameter int DATA_WIDTH = 32,
    localparam int ID_W      = $clog2(CAPACITY),
    localparam int CNT_W     = $clog2(CAPACITY + 1)
)
(
    input logic                  clk,
    input logic                  rst_n,
    input logic                  in_ready,
    input logic                  out_valid,
    input logic                  out_ready,
    input logic [2:0]            status,
    input logic [ID_W-1:0]       result_id,
    input logic [DATA_WIDTH-1:0] result_data,
    input logic [CNT_W-1:0]      live_count
);

    // one request in flight at a time
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        !(in_ready && out_valid))
        else $error("input taken while a result is pending");

    a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(status)
            && $stable(result_id) && $stable(result_data))
        else $error("stalled result changed");

    a_fail_no_data: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status != STS_OK |-> result_data == '0)
        else $error("data on a failed request");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> live_count <= CNT_W'(CAPACITY))
        else $error("live count above capacity");

    a_back_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready |=> in_ready)
        else $error("not ready after result transfer");

endmodule

bind slot_table_with_hole_fifo_unit sta_checker #(
    .CAPACITY   (CAPACITY),
    .DATA_WIDTH (DATA_WIDTH)
) u_sta_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ready    (in_ready),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .status      (status),
    .result_id   (result_id),
    .result_data (result_data),
    .live_count  (live_count)
);
